// File: design/balu_pkg.sv
// Package for the byte ALU with register file: widths, action codes, flag positions
// and the structs passed between the datapath modules. No dependencies.
package balu_pkg;

    localparam int REG_W    = 8;
    localparam int IDX_W    = 5;
    localparam int NUM_REGS = 32;
    localparam int PAIR_W   = 2 * REG_W;
    localparam int ROWS     = NUM_REGS / 2;
    localparam int ROW_W    = IDX_W - 1;
    localparam int INSTR_W  = 16;
    localparam int ACT_W    = 3;
    localparam int STATUS_W = 8;

    typedef logic [ACT_W-1:0] t_action;

    localparam t_action ACT_ADC  = 3'd0;
    localparam t_action ACT_ADD  = 3'd1;
    localparam t_action ACT_ADIW = 3'd2;
    localparam t_action ACT_AND  = 3'd3;
    localparam t_action ACT_ANDI = 3'd4;
    localparam t_action ACT_LOAD = 3'd5;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_N = 2;
    localparam int FLAG_V = 3;
    localparam int FLAG_S = 4;
    localparam int FLAG_H = 5;
    localparam int FLAG_T = 6;
    localparam int FLAG_I = 7;

    localparam logic [IDX_W-1:0] ADIW_BASE = 5'd24;

    typedef struct packed {
        t_action          action;
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] src;
        logic [REG_W-1:0] imm;
    } t_op;

    typedef struct packed {
        logic              we;
        logic [ROW_W-1:0]  row;
        logic [PAIR_W-1:0] data;
    } t_wr;

    typedef struct packed {
        logic [IDX_W-1:0]    dest;
        logic [REG_W-1:0]    lo;
        logic [REG_W-1:0]    hi;
        logic [STATUS_W-1:0] status;
    } t_res;

endpackage

// File: design/balu_ifs.sv
// Valid/ready channel interfaces for the byte ALU: instruction input and result output.
// Depends on balu_pkg for field widths.
interface balu_in_if;
    logic                               valid;
    logic                               ready;
    logic [balu_pkg::ACT_W-1:0]         action;
    logic [balu_pkg::INSTR_W-1:0]       instruction;
    logic [balu_pkg::IDX_W-1:0]         load_index;
    logic [balu_pkg::REG_W-1:0]         load_value;

    modport source (output valid, action, instruction, load_index, load_value, input ready);
    modport sink   (input valid, action, instruction, load_index, load_value, output ready);
endinterface

interface balu_out_if;
    logic                               valid;
    logic                               ready;
    logic [balu_pkg::IDX_W-1:0]         dest_index;
    logic [balu_pkg::REG_W-1:0]         result_low;
    logic [balu_pkg::REG_W-1:0]         result_high;
    logic [balu_pkg::STATUS_W-1:0]      status;

    modport source (output valid, dest_index, result_low, result_high, status, input ready);
    modport sink   (input valid, dest_index, result_low, result_high, status, output ready);
endinterface

// File: design/balu_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Read during write to the same address returns the old contents. No dependencies.
module balu_ram #(
    parameter int P_WIDTH = 16,
    parameter int P_DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/balu_exec.sv
// ALU execute logic: computes the result byte or word, the new status and the row write-back.
// Depends on balu_pkg.
module balu_exec (
    input  balu_pkg::t_op                     i_op,
    input  logic [balu_pkg::PAIR_W-1:0]       i_pair_d,
    input  logic [balu_pkg::PAIR_W-1:0]       i_pair_s,
    input  logic [balu_pkg::STATUS_W-1:0]     i_status,
    output balu_pkg::t_res                    o_res,
    output balu_pkg::t_wr                     o_wr
);

    logic [balu_pkg::REG_W-1:0]    a;
    logic [balu_pkg::REG_W-1:0]    b;
    logic                          cin;
    logic [balu_pkg::REG_W:0]      sum9;
    logic [balu_pkg::REG_W-1:0]    add_res;
    logic [balu_pkg::REG_W-1:0]    carry_v;
    logic [balu_pkg::REG_W-1:0]    ovf_v;
    logic [balu_pkg::REG_W-1:0]    and_res;
    logic [balu_pkg::PAIR_W-1:0]   w_res;
    logic [balu_pkg::REG_W-1:0]    byte_out;
    logic [balu_pkg::STATUS_W-1:0] st;

    always_comb begin
        a   = i_op.dest[0] ? i_pair_d[balu_pkg::PAIR_W-1:balu_pkg::REG_W]
                           : i_pair_d[balu_pkg::REG_W-1:0];
        b   = i_op.src[0]  ? i_pair_s[balu_pkg::PAIR_W-1:balu_pkg::REG_W]
                           : i_pair_s[balu_pkg::REG_W-1:0];
        cin = (i_op.action == balu_pkg::ACT_ADC) ? i_status[balu_pkg::FLAG_C] : 1'b0;

        sum9    = {1'b0, a} + {1'b0, b} + {{balu_pkg::REG_W{1'b0}}, cin};
        add_res = sum9[balu_pkg::REG_W-1:0];
        carry_v = (a & b) | (b & ~add_res) | (~add_res & a);
        ovf_v   = (a & b & ~add_res) | (~a & ~b & add_res);

        and_res = (i_op.action == balu_pkg::ACT_ANDI) ? (a & i_op.imm) : (a & b);
        w_res   = i_pair_d + {{(balu_pkg::PAIR_W - 6){1'b0}}, i_op.imm[5:0]};

        st       = i_status;
        byte_out = '0;
        o_res    = '0;
        o_wr.we  = 1'b0;
        o_wr.row = i_op.dest[balu_pkg::IDX_W-1:1];

        case (i_op.action) inside
            balu_pkg::ACT_ADC, balu_pkg::ACT_ADD: begin
                byte_out            = add_res;
                st[balu_pkg::FLAG_H] = carry_v[3];
                st[balu_pkg::FLAG_V] = ovf_v[7];
                st[balu_pkg::FLAG_N] = add_res[7];
                st[balu_pkg::FLAG_Z] = (add_res == '0);
                st[balu_pkg::FLAG_C] = carry_v[7];
                st[balu_pkg::FLAG_S] = add_res[7] ^ ovf_v[7];
                o_wr.we             = 1'b1;
                o_res.dest          = i_op.dest;
            end
            balu_pkg::ACT_AND, balu_pkg::ACT_ANDI: begin
                byte_out            = and_res;
                st[balu_pkg::FLAG_V] = 1'b0;
                st[balu_pkg::FLAG_N] = and_res[7];
                st[balu_pkg::FLAG_Z] = (and_res == '0);
                st[balu_pkg::FLAG_S] = and_res[7];
                o_wr.we             = 1'b1;
                o_res.dest          = i_op.dest;
            end
            balu_pkg::ACT_LOAD: begin
                byte_out   = i_op.imm;
                o_wr.we    = 1'b1;
                o_res.dest = i_op.dest;
            end
            default: begin
                byte_out = '0;
            end
        endcase

        o_res.lo = byte_out;
        o_wr.data = i_op.dest[0] ? {byte_out, i_pair_d[balu_pkg::REG_W-1:0]}
                                 : {i_pair_d[balu_pkg::PAIR_W-1:balu_pkg::REG_W], byte_out};

        if (i_op.action == balu_pkg::ACT_ADIW) begin
            st[balu_pkg::FLAG_V] = ~i_pair_d[15] & w_res[15];
            st[balu_pkg::FLAG_N] = w_res[15];
            st[balu_pkg::FLAG_Z] = (w_res == '0);
            st[balu_pkg::FLAG_C] = ~w_res[15] & i_pair_d[15];
            st[balu_pkg::FLAG_S] = w_res[15] ^ (~i_pair_d[15] & w_res[15]);
            o_wr.we              = 1'b1;
            o_wr.data            = w_res;
            o_res.dest           = i_op.dest;
            o_res.lo             = w_res[balu_pkg::REG_W-1:0];
            o_res.hi             = w_res[balu_pkg::PAIR_W-1:balu_pkg::REG_W];
        end

        o_res.status = st;
    end

endmodule

// File: design/byte_alu_with_register_file_core.sv
// Top level of the byte ALU with register file: decode, register-file memories, execute stage
// and output register. Depends on balu_pkg, balu_ifs, balu_ram and balu_exec.
//
// One instruction per clock unless the output stalls: a transaction on the input is decoded
// and its register pairs are read from two 16 x 16-bit register-file copies (one per operand,
// rows hold an even/odd register pair); once the output register can take the result, the
// execute stage computes, writes the row back to both copies and loads the output register.
// The last write-back is forwarded to the execute stage, so dependent instructions follow
// back to back. The output register decouples the sides: input ready drops only while the
// execute stage is full, a result is held and the output side is not ready. Register file
// and status are zero after reset; each row has a valid bit, so no clearing pass is needed.
module byte_alu_with_register_file_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    balu_in_if.sink          i_in,
    balu_out_if.source       o_out
);

    balu_pkg::t_op                     dec_op;
    balu_pkg::t_op                     r_op;
    logic                              r_s1_valid;
    logic                              in_go;
    logic                              s1_go;
    logic [balu_pkg::PAIR_W-1:0]       ram_d;
    logic [balu_pkg::PAIR_W-1:0]       ram_s;
    logic [balu_pkg::PAIR_W-1:0]       pair_d;
    logic [balu_pkg::PAIR_W-1:0]       pair_s;
    logic [balu_pkg::ROWS-1:0]         r_row_valid;
    logic [balu_pkg::ROWS-1:0]         n_row_valid;
    logic                              r_fwd_valid;
    logic [balu_pkg::ROW_W-1:0]        r_fwd_row;
    logic [balu_pkg::PAIR_W-1:0]       r_fwd_data;
    logic [balu_pkg::STATUS_W-1:0]     r_status;
    logic                              r_out_valid;
    balu_pkg::t_res                    r_out;
    balu_pkg::t_res                    ex_res;
    balu_pkg::t_wr                     ex_wr;
    logic                              wr_en;
    logic [balu_pkg::ROW_W-1:0]        row_d;
    logic [balu_pkg::ROW_W-1:0]        row_s;

    always_comb begin
        dec_op.action = i_in.action;
        dec_op.dest   = {i_in.instruction[8], i_in.instruction[7:4]};
        dec_op.src    = {i_in.instruction[9], i_in.instruction[3:0]};
        dec_op.imm    = '0;
        unique case (i_in.action)
            balu_pkg::ACT_ADIW: begin
                dec_op.dest = balu_pkg::ADIW_BASE + {2'b00, i_in.instruction[5:4], 1'b0};
                dec_op.imm  = {2'b00, i_in.instruction[7:6], i_in.instruction[3:0]};
            end
            balu_pkg::ACT_ANDI: begin
                dec_op.dest = {1'b1, i_in.instruction[7:4]};
                dec_op.imm  = {i_in.instruction[11:8], i_in.instruction[3:0]};
            end
            balu_pkg::ACT_LOAD: begin
                dec_op.dest = i_in.load_index;
                dec_op.imm  = i_in.load_value;
            end
            default: begin
                dec_op.imm = '0;
            end
        endcase
    end

    assign s1_go       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_s1_valid || s1_go;
    assign in_go       = i_in.valid && i_in.ready;
    assign wr_en       = s1_go && ex_wr.we;
    assign row_d       = r_op.dest[balu_pkg::IDX_W-1:1];
    assign row_s       = r_op.src[balu_pkg::IDX_W-1:1];

    balu_ram #(
        .P_WIDTH (balu_pkg::PAIR_W),
        .P_DEPTH (balu_pkg::ROWS)
    ) u_ram_d (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ex_wr.row),
        .i_wdata (ex_wr.data),
        .i_re    (in_go),
        .i_raddr (dec_op.dest[balu_pkg::IDX_W-1:1]),
        .o_rdata (ram_d)
    );

    balu_ram #(
        .P_WIDTH (balu_pkg::PAIR_W),
        .P_DEPTH (balu_pkg::ROWS)
    ) u_ram_s (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ex_wr.row),
        .i_wdata (ex_wr.data),
        .i_re    (in_go),
        .i_raddr (dec_op.src[balu_pkg::IDX_W-1:1]),
        .o_rdata (ram_s)
    );

    always_comb begin
        if (r_fwd_valid && r_fwd_row == row_d) begin
            pair_d = r_fwd_data;
        end else if (r_row_valid[row_d]) begin
            pair_d = ram_d;
        end else begin
            pair_d = '0;
        end
        if (r_fwd_valid && r_fwd_row == row_s) begin
            pair_s = r_fwd_data;
        end else if (r_row_valid[row_s]) begin
            pair_s = ram_s;
        end else begin
            pair_s = '0;
        end
        n_row_valid = r_row_valid;
        if (wr_en) begin
            n_row_valid[ex_wr.row] = 1'b1;
        end
    end

    balu_exec u_exec (
        .i_op     (r_op),
        .i_pair_d (pair_d),
        .i_pair_s (pair_s),
        .i_status (r_status),
        .o_res    (ex_res),
        .o_wr     (ex_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_row_valid <= '0;
            r_fwd_valid <= 1'b0;
            r_status    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_go) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            r_row_valid <= n_row_valid;
            if (wr_en) begin
                r_fwd_valid <= 1'b1;
            end
            if (s1_go) begin
                r_status    <= ex_res.status;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_op <= dec_op;
        end
        if (wr_en) begin
            r_fwd_row  <= ex_wr.row;
            r_fwd_data <= ex_wr.data;
        end
        if (s1_go) begin
            r_out <= ex_res;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.dest_index  = r_out.dest;
    assign o_out.result_low  = r_out.lo;
    assign o_out.result_high = r_out.hi;
    assign o_out.status      = r_out.status;

    a_tflag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_status[balu_pkg::FLAG_I:balu_pkg::FLAG_T] == 2'b00)
        else $error("T or I status bit set");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_go |=> r_s1_valid && $stable(r_op))
        else $error("stalled execute stage lost its instruction");

    a_fwd_row_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_valid |-> r_row_valid[r_fwd_row])
        else $error("forwarded row not marked valid");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> r_row_valid == '0 && !r_out_valid && !r_s1_valid)
        else $error("reset did not clear control state");

endmodule

// File: sim/testbench.sv
// Regression for byte_alu_with_register_file_core: directed flag cases, dependent chains
// and a random mix, all checked against a shadow register file and status register.
// Depends on balu_pkg, balu_ifs and the core RTL.
`timescale 1ns / 1ps

module testbench;
    import balu_pkg::*;

    localparam t_action ACT_RSVD_6  = 3'd6;
    localparam t_action ACT_RSVD_7  = 3'd7;
    localparam int      CYCLE_LIMIT = 500_000;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

    logic       clk = 1'b0;
    logic       rst_n;
    idle_mode_t idle_mode = IDLE_NONE;
    int         sink_hold = 0;
    int         cycle_count = 0;
    int         mismatch_count = 0;

    logic [REG_W-1:0]    shadow_regs [NUM_REGS];
    logic [STATUS_W-1:0] shadow_status;
    t_res                predicted_results [$];

    balu_in_if  instr_ch ();
    balu_out_if result_ch ();

    byte_alu_with_register_file_core i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        case (idle_mode)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: begin
                if (r < 80) return 0;
                if (r < 97) return $urandom_range(1, 3);
                return $urandom_range(10, 40);
            end
            default: begin
                if (r < 45) return 0;
                if (r < 90) return $urandom_range(1, 4);
                return $urandom_range(10, 40);
            end
        endcase
    endfunction

    function automatic logic [REG_W-1:0] pick_byte();
        if ($urandom_range(0, 9) < 3) begin
            case ($urandom_range(0, 4))
                0: return 8'h00;
                1: return 8'h01;
                2: return 8'h7F;
                3: return 8'h80;
                default: return 8'hFF;
            endcase
        end
        return REG_W'($urandom);
    endfunction

    function automatic logic [INSTR_W-1:0] rr_word(logic [IDX_W-1:0] d, logic [IDX_W-1:0] r);
        return {6'b0, r[4], d[4], d[3:0], r[3:0]};
    endfunction

    function automatic logic [INSTR_W-1:0] andi_word(logic [IDX_W-1:0] d, logic [REG_W-1:0] k);
        return {4'b0, k[7:4], d[3:0], k[3:0]};
    endfunction

    function automatic logic [INSTR_W-1:0] adiw_word(logic [1:0] pair, logic [5:0] k);
        return {8'b0, k[5:4], pair, k[3:0]};
    endfunction

    // Execute one instruction on the shadow state and return the result it should produce.
    function automatic t_res predict_alu(t_action act, logic [INSTR_W-1:0] ins,
                                         logic [IDX_W-1:0] li, logic [REG_W-1:0] lv);
        logic [IDX_W-1:0]  rd;
        logic [IDX_W-1:0]  rr;
        logic [IDX_W-1:0]  pidx;
        logic [REG_W-1:0]  a;
        logic [REG_W-1:0]  b;
        logic [REG_W-1:0]  sum;
        logic [REG_W-1:0]  nsum;
        logic [PAIR_W-1:0] old_word;
        logic [PAIR_W-1:0] new_word;
        logic              cin;
        t_res              r;
        rd = {ins[8], ins[7:4]};
        rr = {ins[9], ins[3:0]};
        r  = '0;
        case (act)
            ACT_ADC, ACT_ADD: begin
                a    = shadow_regs[rd];
                b    = shadow_regs[rr];
                cin  = (act == ACT_ADC) ? shadow_status[FLAG_C] : 1'b0;
                sum  = a + b + {7'd0, cin};
                nsum = ~sum;
                shadow_status[FLAG_H] = (a[3] & b[3]) | (b[3] & nsum[3]) | (nsum[3] & a[3]);
                shadow_status[FLAG_V] = (a[7] & b[7] & nsum[7]) | (~a[7] & ~b[7] & sum[7]);
                shadow_status[FLAG_N] = sum[7];
                shadow_status[FLAG_Z] = (sum == '0);
                shadow_status[FLAG_C] = (a[7] & b[7]) | (b[7] & nsum[7]) | (nsum[7] & a[7]);
                shadow_status[FLAG_S] = shadow_status[FLAG_N] ^ shadow_status[FLAG_V];
                shadow_regs[rd] = sum;
                r.dest = rd;
                r.lo   = sum;
            end
            ACT_ADIW: begin
                pidx     = ADIW_BASE + {2'b00, ins[5:4], 1'b0};
                old_word = {shadow_regs[pidx + 5'd1], shadow_regs[pidx]};
                new_word = old_word + {10'd0, ins[7:6], ins[3:0]};
                shadow_status[FLAG_V] = ~old_word[15] & new_word[15];
                shadow_status[FLAG_N] = new_word[15];
                shadow_status[FLAG_Z] = (new_word == '0);
                shadow_status[FLAG_C] = ~new_word[15] & old_word[15];
                shadow_status[FLAG_S] = shadow_status[FLAG_N] ^ shadow_status[FLAG_V];
                shadow_regs[pidx]         = new_word[7:0];
                shadow_regs[pidx + 5'd1]  = new_word[15:8];
                r.dest = pidx;
                r.lo   = new_word[7:0];
                r.hi   = new_word[15:8];
            end
            ACT_AND, ACT_ANDI: begin
                if (act == ACT_ANDI) begin
                    rd = {1'b1, ins[7:4]};
                    b  = {ins[11:8], ins[3:0]};
                end else begin
                    b = shadow_regs[rr];
                end
                sum = shadow_regs[rd] & b;
                shadow_status[FLAG_V] = 1'b0;
                shadow_status[FLAG_N] = sum[7];
                shadow_status[FLAG_Z] = (sum == '0);
                shadow_status[FLAG_S] = shadow_status[FLAG_N] ^ shadow_status[FLAG_V];
                shadow_regs[rd] = sum;
                r.dest = rd;
                r.lo   = sum;
            end
            ACT_LOAD: begin
                shadow_regs[li] = lv;
                r.dest = li;
                r.lo   = lv;
            end
            default: ;
        endcase
        r.status = shadow_status;
        return r;
    endfunction

    task automatic issue_instr(t_action act, logic [INSTR_W-1:0] ins,
                               logic [IDX_W-1:0] li, logic [REG_W-1:0] lv);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        instr_ch.valid       <= 1'b1;
        instr_ch.action      <= act;
        instr_ch.instruction <= ins;
        instr_ch.load_index  <= li;
        instr_ch.load_value  <= lv;
        @(posedge clk);
        while (!instr_ch.ready) @(posedge clk);
        predicted_results.push_back(predict_alu(act, ins, li, lv));
    endtask

    task automatic check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge clk) begin
        if (sink_hold != 0) begin
            result_ch.ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            result_ch.ready <= 1'b1;
            sink_hold <= pick_idle();
        end
    end

    always @(posedge clk) begin
        t_res exp_res;
        if (rst_n && result_ch.valid && result_ch.ready) begin
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected transaction, expected none, actual %0h %0h %0h %0h",
                         $time, result_ch.dest_index, result_ch.result_low,
                         result_ch.result_high, result_ch.status);
            end else begin
                exp_res = predicted_results.pop_front();
                check_field("dest_index", exp_res.dest, result_ch.dest_index);
                check_field("result_low", exp_res.lo, result_ch.result_low);
                check_field("result_high", exp_res.hi, result_ch.result_high);
                check_field("status", exp_res.status, result_ch.status);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("byte_alu_with_register_file_core regression: fail");
            $finish;
        end
    end

    task automatic test_directed_flags();
        idle_mode = IDLE_NONE;
        issue_instr(ACT_LOAD, 16'h0000, 5'd1, 8'hFF);
        issue_instr(ACT_LOAD, 16'hFFFF, 5'd2, 8'h01);
        issue_instr(ACT_ADD, rr_word(5'd1, 5'd2), 5'd0, 8'h00);
        issue_instr(ACT_ADC, rr_word(5'd1, 5'd2), 5'd31, 8'hFF);
        issue_instr(ACT_LOAD, 16'h0000, 5'd17, 8'h7F);
        issue_instr(ACT_LOAD, 16'h0000, 5'd31, 8'h01);
        issue_instr(ACT_ADD, rr_word(5'd17, 5'd31), 5'd0, 8'h00);
        issue_instr(ACT_ADD, 16'hFFFF, 5'd0, 8'h00);
        issue_instr(ACT_ADC, 16'h0000, 5'd0, 8'h00);
        issue_instr(ACT_AND, rr_word(5'd17, 5'd17), 5'd0, 8'h00);
        issue_instr(ACT_AND, rr_word(5'd1, 5'd0), 5'd0, 8'h00);
        issue_instr(ACT_ANDI, andi_word(5'd31, 8'hFF), 5'd0, 8'h00);
        issue_instr(ACT_ANDI, andi_word(5'd16, 8'h00), 5'd0, 8'h00);
        issue_instr(ACT_ANDI, 16'hFFFF, 5'd0, 8'h00);
        issue_instr(ACT_LOAD, 16'h0000, 5'd24, 8'hFF);
        issue_instr(ACT_LOAD, 16'h0000, 5'd25, 8'hFF);
        issue_instr(ACT_ADIW, adiw_word(2'd0, 6'd63), 5'd0, 8'h00);
        issue_instr(ACT_LOAD, 16'h0000, 5'd30, 8'hFF);
        issue_instr(ACT_LOAD, 16'h0000, 5'd31, 8'h7F);
        issue_instr(ACT_ADIW, adiw_word(2'd3, 6'd1), 5'd0, 8'h00);
        issue_instr(ACT_ADIW, adiw_word(2'd1, 6'd0), 5'd0, 8'h00);
        issue_instr(ACT_ADIW, 16'hFFFF, 5'd0, 8'h00);
        issue_instr(ACT_RSVD_6, 16'hFFFF, 5'd31, 8'hFF);
        issue_instr(ACT_RSVD_7, 16'h0000, 5'd0, 8'h00);
        issue_instr(ACT_LOAD, 16'hFFFF, 5'd0, 8'h00);
    endtask

    task automatic test_dependent_chains();
        logic [IDX_W-1:0] d;
        logic [IDX_W-1:0] r;
        logic [1:0]       pair;
        t_action          act;
        int               n;
        for (int c = 0; c < 20; c++) begin
            idle_mode = (c % 2 == 0) ? IDLE_NONE : IDLE_LIGHT;
            d = IDX_W'($urandom);
            r = IDX_W'($urandom);
            issue_instr(ACT_LOAD, INSTR_W'($urandom), d, pick_byte());
            issue_instr(ACT_LOAD, INSTR_W'($urandom), r, pick_byte());
            n = $urandom_range(3, 7);
            repeat (n) begin
                case ($urandom_range(0, 2))
                    0: act = ACT_ADC;
                    1: act = ACT_ADD;
                    default: act = ACT_AND;
                endcase
                issue_instr(act, rr_word(d, r) | {6'($urandom), 10'b0},
                            IDX_W'($urandom), REG_W'($urandom));
            end
            if (d[4])
                issue_instr(ACT_ANDI, andi_word(d, pick_byte()), IDX_W'($urandom),
                            REG_W'($urandom));
            pair = 2'($urandom);
            issue_instr(ACT_LOAD, INSTR_W'($urandom), ADIW_BASE + {2'b00, pair, 1'b0},
                        pick_byte());
            issue_instr(ACT_LOAD, INSTR_W'($urandom), ADIW_BASE + {2'b00, pair, 1'b1},
                        pick_byte());
            n = $urandom_range(3, 7);
            repeat (n)
                issue_instr(ACT_ADIW, adiw_word(pair, 6'($urandom)) | {8'($urandom), 8'b0},
                            IDX_W'($urandom), REG_W'($urandom));
            issue_instr(t_action'($urandom), INSTR_W'($urandom), IDX_W'($urandom),
                        REG_W'($urandom));
        end
    endtask

    task automatic test_random_mix();
        t_action act;
        int      r;
        for (int i = 0; i < 900; i++) begin
            if (i % 100 == 0)
                idle_mode = idle_mode_t'((i / 100) % 3);
            r = $urandom_range(0, 99);
            if (r < 22)       act = ACT_LOAD;
            else if (r < 37)  act = ACT_ADC;
            else if (r < 52)  act = ACT_ADD;
            else if (r < 66)  act = ACT_ADIW;
            else if (r < 80)  act = ACT_AND;
            else if (r < 96)  act = ACT_ANDI;
            else if (r < 98)  act = ACT_RSVD_6;
            else              act = ACT_RSVD_7;
            issue_instr(act, INSTR_W'($urandom), IDX_W'($urandom), pick_byte());
        end
    endtask

    initial begin
        foreach (shadow_regs[i])
            shadow_regs[i] = '0;
        shadow_status = '0;
        rst_n                <= 1'b0;
        instr_ch.valid       <= 1'b0;
        instr_ch.action      <= ACT_ADD;
        instr_ch.instruction <= '0;
        instr_ch.load_index  <= '0;
        instr_ch.load_value  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_flags();
        test_dependent_chains();
        test_random_mix();

        instr_ch.valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("byte_alu_with_register_file_core regression: pass");
        else
            $display("byte_alu_with_register_file_core regression: fail");
        $finish;
    end

endmodule
